[design/uer_pkg.sv]
// ============================================================================
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// Event record passed from the tick sequencer to the filter, status codes,
// register indexes and the constants of the moving-average divider.
// ============================================================================
`default_nettype none

package uer_pkg;

  // Moving-average depth and result widths
  localparam int FILTER_DEPTH = 5;
  localparam int RAW_W        = 17;
  localparam int RAW_MAX      = 36000;
  localparam int TICK_W       = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;

  // Ring index and saturating fill count (holds FILTER_DEPTH + 1)
  localparam int POS_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int CNT_W = $clog2(FILTER_DEPTH + 2);

  // Ring sum magnitude, signed sum, reciprocal multiply for the mean
  localparam int MAG_W  = $clog2(FILTER_DEPTH * RAW_MAX + FILTER_DEPTH / 2 + 1);
  localparam int SUM_W  = MAG_W + 1;
  localparam int DIV_S  = MAG_W + $clog2(FILTER_DEPTH);
  localparam int DIV_MW = MAG_W + 2;
  localparam longint unsigned DIV_M =
    ((64'd1 << DIV_S) + FILTER_DEPTH - 1) / FILTER_DEPTH;
  localparam int PROD_W = MAG_W + DIV_MW;
  localparam int HALF   = FILTER_DEPTH / 2;

  // Distance scale: ticks * 1124 >> 8 gives 1/256 cm
  localparam int SCALE_W = 11;
  localparam logic [SCALE_W-1:0] DIST_SCALE = 11'd1124;
  localparam logic signed [RAW_W-1:0] DIST_TIMEOUT = -17'sd256;
  localparam logic signed [RAW_W-1:0] DIST_RANGE   = 17'sd25600;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ECHO      = 2'd2;

  // Event queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One tick's outcome, before filtering
  typedef struct packed {
    logic                    trig;
    logic                    busy;
    logic                    done;
    logic [1:0]              status;
    logic signed [RAW_W-1:0] raw;
  } uer_evt_t;

endpackage

`default_nettype wire

[design/uer_front.sv]
// ============================================================================
// uer_front: tick sequencer
// Runs the trigger / wait-for-echo / measure sequence one tick per transfer,
// holds the configuration registers and emits one event per tick.
// ============================================================================
`default_nettype none

module uer_front
  import uer_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  input  wire logic                 q_full,
  input  wire logic                 start_req,
  input  wire logic                 echo_level,
  output logic                      in_stall,
  output logic                      push,
  output uer_evt_t                  evt
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_MEAS = 4'b1000
  } phase_t;

  phase_t              phase, phase_next;
  logic [TICK_W-1:0]   tick_count, tick_count_next, tick_inc;
  logic [7:0]          trigger_ticks;
  logic [15:0]         echo_timeout_ticks;
  logic [12:0]         max_echo_ticks;
  logic [TICK_W+SCALE_W-1:0] scaled;

  assign in_stall = q_full;
  assign push     = in_valid && !in_stall;
  assign tick_inc = tick_count + 1'b1;
  assign scaled   = tick_count * DIST_SCALE;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks      <= 8'd20;
      echo_timeout_ticks <= 16'd20000;
      max_echo_ticks     <= 13'd5850;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRIGGER_TICKS: trigger_ticks      <= cfg_data[7:0];
        REG_ECHO_TIMEOUT:  echo_timeout_ticks <= cfg_data[15:0];
        REG_MAX_ECHO:      max_echo_ticks     <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Sequencer next state and event
  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    evt             = '0;
    unique case (phase)
      PH_IDLE: begin
        if (start_req) begin
          evt.trig = 1'b1;
          if (trigger_ticks <= 8'd1) begin
            phase_next      = PH_WAIT;
            tick_count_next = '0;
          end else begin
            phase_next      = PH_TRIG;
            tick_count_next = TICK_W'(1);
          end
        end
      end
      PH_TRIG: begin
        evt.trig        = 1'b1;
        tick_count_next = tick_inc;
        if (tick_inc >= {8'd0, trigger_ticks}) begin
          phase_next      = PH_WAIT;
          tick_count_next = '0;
        end
      end
      PH_WAIT: begin
        if (echo_level) begin
          phase_next      = PH_MEAS;
          tick_count_next = TICK_W'(1);
        end else if (tick_count >= echo_timeout_ticks) begin
          evt.done        = 1'b1;
          evt.status      = ST_TIMEOUT;
          evt.raw         = DIST_TIMEOUT;
          phase_next      = PH_IDLE;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_MEAS: begin
        if (echo_level) begin
          // width saturates at full scale
          if (tick_count != {TICK_W{1'b1}}) tick_count_next = tick_inc;
        end else begin
          evt.done        = 1'b1;
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          if (tick_count > {3'd0, max_echo_ticks}) begin
            evt.status = ST_RANGE;
            evt.raw    = DIST_RANGE;
          end else begin
            evt.status = ST_OK;
            evt.raw    = $signed(scaled[8 +: RAW_W]);
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase
    evt.busy = (phase_next != PH_IDLE);
  end

  // Sequencer state, advanced once per input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
    end else if (push) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

`default_nettype wire

[design/uer_queue.sv]
// ============================================================================
// uer_queue: event queue
// Small FIFO of tick events between the sequencer and the filter pipeline.
// ============================================================================
`default_nettype none

module uer_queue
  import uer_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire uer_evt_t push_evt,
  input  wire logic     pop,
  output logic          full,
  output logic          not_empty,
  output uer_evt_t      head
);

  uer_evt_t             entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wptr, rptr;
  logic [Q_CNT_W-1:0]   count;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_evt;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/uer_back.sv]
// ============================================================================
// uer_back: filter pipeline
// Keeps the ring of recent results with a running sum, divides the sum by
// the depth with a reciprocal multiply, and holds the output register.
// ============================================================================
`default_nettype none

module uer_back
  import uer_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire uer_evt_t      q_evt,
  output logic               q_pop,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic               trigger_out,
  output logic               busy_res,
  output logic               done_res,
  output logic [1:0]         status,
  output logic signed [RAW_W-1:0] raw_distance,
  output logic signed [RAW_W-1:0] filtered_distance
);

  // Filter state
  logic signed [RAW_W-1:0] ring [FILTER_DEPTH];
  logic [POS_W-1:0]        ring_pos, pos_new;
  logic [CNT_W-1:0]        sample_cnt;
  logic signed [SUM_W-1:0] ring_sum, sum_new;

  // Stage registers
  logic                    a_valid, b_valid;
  uer_evt_t                a_evt, b_evt;
  logic signed [SUM_W-1:0] a_sum;
  logic                    a_use_raw, b_use_raw, b_neg;
  logic [PROD_W-1:0]       b_prod;

  logic                    rdy_a, rdy_b, rdy_c;
  logic [SUM_W-1:0]        a_abs;
  logic [MAG_W-1:0]        a_mag;
  logic signed [RAW_W-1:0] quot;

  // Ready chain: a stage loads when it is empty or its content moves on
  assign rdy_c = !out_valid || !out_stall;
  assign rdy_b = !b_valid || rdy_c;
  assign rdy_a = !a_valid || rdy_b;
  assign q_pop = q_valid && rdy_a;

  assign pos_new = (ring_pos == POS_W'(FILTER_DEPTH - 1)) ? '0 : ring_pos + 1'b1;
  assign sum_new = ring_sum - SUM_W'(ring[pos_new]) + SUM_W'(q_evt.raw);

  // Stage A: ring update on each completed measurement
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pos   <= '0;
      sample_cnt <= '0;
      ring_sum   <= '0;
      for (int i = 0; i < FILTER_DEPTH; i++) ring[i] <= '0;
    end else if (q_pop && q_evt.done) begin
      ring_pos       <= pos_new;
      ring[pos_new]  <= q_evt.raw;
      ring_sum       <= sum_new;
      if (sample_cnt <= CNT_W'(FILTER_DEPTH)) sample_cnt <= sample_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (rdy_a) a_valid <= q_pop;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_evt     <= q_evt;
      a_sum     <= sum_new;
      a_use_raw <= (sample_cnt < CNT_W'(FILTER_DEPTH));
    end
  end

  // Stage B: magnitude plus half, times the reciprocal of the depth
  assign a_abs = a_sum[SUM_W-1] ? $unsigned(-a_sum) : $unsigned(a_sum);
  assign a_mag = MAG_W'(a_abs) + MAG_W'(HALF);

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (rdy_b) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy_b && a_valid) begin
      b_evt     <= a_evt;
      b_use_raw <= a_use_raw;
      b_neg     <= a_sum[SUM_W-1];
      b_prod    <= PROD_W'(a_mag) * PROD_W'(DIV_M[DIV_MW-1:0]);
    end
  end

  // Stage C: output register
  assign quot = $signed(RAW_W'(b_prod >> DIV_S));

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (rdy_c) out_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy_c && b_valid) begin
      trigger_out  <= b_evt.trig;
      busy_res     <= b_evt.busy;
      done_res     <= b_evt.done;
      status       <= b_evt.status;
      raw_distance <= b_evt.raw;
      if (!b_evt.done)    filtered_distance <= '0;
      else if (b_use_raw) filtered_distance <= b_evt.raw;
      else if (b_neg)     filtered_distance <= -quot;
      else                filtered_distance <= quot;
    end
  end

endmodule

`default_nettype wire

[design/ultrasonic_echo_ranger.sv]
// ============================================================================
// ultrasonic_echo_ranger: ultrasonic ranging with moving-average filter
//
//   channel   direction  handshake            payload
//   input     in         in_valid/in_stall    start_req, echo_level
//   result    out        out_valid/out_stall  trigger_out, busy_res, done_res,
//                                             status, raw_distance,
//                                             filtered_distance
//   config    in         cfg_we               cfg_index, cfg_data
//
// One tick is taken per cycle while in_stall is low; its result passes through the
// queue entry, ring update, divider multiply and output register.
// Sync reset loads the register defaults and clears the five-entry ring.
// in_stall rises only when the four-entry event queue is full, which happens
// only after out_stall has held the filter pipeline.
// ============================================================================
`default_nettype none

module ultrasonic_echo_ranger
  import uer_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 start_req,
  input  wire logic                 echo_level,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      trigger_out,
  output logic                      busy_res,
  output logic                      done_res,
  output logic [1:0]                status,
  output logic signed [RAW_W-1:0]   raw_distance,
  output logic signed [RAW_W-1:0]   filtered_distance
);

  logic     push, q_full, q_valid, q_pop;
  uer_evt_t push_evt, q_head;

  uer_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .q_full     (q_full),
    .start_req  (start_req),
    .echo_level (echo_level),
    .in_stall   (in_stall),
    .push       (push),
    .evt        (push_evt)
  );

  uer_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_evt  (push_evt),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  uer_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_evt             (q_head),
    .q_pop             (q_pop),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .trigger_out       (trigger_out),
    .busy_res          (busy_res),
    .done_res          (done_res),
    .status            (status),
    .raw_distance      (raw_distance),
    .filtered_distance (filtered_distance)
  );

  // A completed measurement always returns to idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done result reported busy");

  // Ticks without completion carry zero status and distances
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> status == ST_OK && raw_distance == '0
                               && filtered_distance == '0)
    else $error("non-done result with nonzero payload");

  // A driven trigger always means a measurement is under way
  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && trigger_out |-> busy_res && !done_res)
    else $error("trigger high outside a measurement");

  // Timeout results carry the fixed timeout distance
  a_timeout_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res && status == ST_TIMEOUT |-> raw_distance == DIST_TIMEOUT)
    else $error("timeout with wrong distance");

endmodule

`default_nettype wire
